[src/sm64br_pkg.sv]
// Shared constants and control types for the splitmix64 bounded random generator.
package sm64br_pkg;

    localparam int STATE_W = 64;
    localparam int HALF_W  = 32;
    localparam int BOUND_W = 32;
    localparam int CNT_W   = 6;

    localparam logic [STATE_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [STATE_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [STATE_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    localparam int MUL_STEPS = 3;
    localparam int DIV_STEPS = 64;

    localparam logic [1:0] PP_LO_LO = 2'd0;
    localparam logic [1:0] PP_LO_HI = 2'd1;
    localparam logic [1:0] PP_HI_LO = 2'd2;

    typedef struct packed {
        logic       start;
        logic       mul_en;
        logic [1:0] pp_sel;
        logic       rnd;
        logic       acc_load;
        logic       acc_add;
        logic       mix_b;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } ctl_t;

endpackage

[src/sm64br_ctrl.sv]
// Sequencer for the splitmix64 bounded random generator: handshakes and step commands.
module sm64br_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sm64br_pkg::ctl_t   ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_MIX  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [sm64br_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         round_reg, round_next;
    logic                         out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.start  = 1'b1;
                    cnt_next   = '0;
                    round_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctl.mul_en   = (cnt_reg < sm64br_pkg::CNT_W'(sm64br_pkg::MUL_STEPS));
                ctl.pp_sel   = cnt_reg[1:0];
                ctl.rnd      = round_reg;
                ctl.acc_load = (cnt_reg == sm64br_pkg::CNT_W'(1));
                ctl.acc_add  = (cnt_reg >= sm64br_pkg::CNT_W'(2));
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sm64br_pkg::CNT_W'(sm64br_pkg::MUL_STEPS)) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                cnt_next = '0;
                if (!round_reg) begin
                    ctl.mix_b  = 1'b1;
                    round_next = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    ctl.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sm64br_pkg::CNT_W'(sm64br_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            round_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/sm64br_dp.sv]
// Datapath for the splitmix64 bounded random generator: state, mixer and restoring divider.
module sm64br_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sm64br_pkg::ctl_t               ctl,
    input  logic [sm64br_pkg::BOUND_W-1:0] s_bound,
    output logic [sm64br_pkg::BOUND_W-1:0] m_value,
    output logic                           m_bound_error
);

    localparam int SW = sm64br_pkg::STATE_W;
    localparam int HW = sm64br_pkg::HALF_W;
    localparam int BW = sm64br_pkg::BOUND_W;

    logic [SW-1:0] gen_state_reg;
    logic [SW-1:0] z_reg;
    logic [SW-1:0] pp_reg;
    logic [SW-1:0] acc_reg;
    logic [SW-1:0] dvd_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] bound_reg;
    logic [BW-1:0] value_reg;
    logic          err_reg;

    logic [SW-1:0] state_adv;
    logic [SW-1:0] mul_const;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [BW:0]   trial;
    logic          fits;

    assign state_adv = gen_state_reg + sm64br_pkg::GOLDEN_INC;
    assign mul_const = ctl.rnd ? sm64br_pkg::MIX_MUL_B : sm64br_pkg::MIX_MUL_A;
    assign mul_a     = (ctl.pp_sel == sm64br_pkg::PP_HI_LO) ? z_reg[SW-1:HW] : z_reg[HW-1:0];
    assign mul_b     = (ctl.pp_sel == sm64br_pkg::PP_LO_HI) ? mul_const[SW-1:HW]
                                                            : mul_const[HW-1:0];
    assign trial     = {rem_reg, dvd_reg[SW-1]};
    assign fits      = (trial >= {1'b0, bound_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= sm64br_pkg::GOLDEN_INC;
        end else if (ctl.start) begin
            gen_state_reg <= state_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            bound_reg <= s_bound;
            z_reg     <= state_adv ^ (state_adv >> sm64br_pkg::MIX_SHIFT_A);
        end else if (ctl.mix_b) begin
            z_reg     <= acc_reg ^ (acc_reg >> sm64br_pkg::MIX_SHIFT_B);
        end
        if (ctl.mul_en) begin
            pp_reg <= SW'(mul_a) * SW'(mul_b);
        end
        if (ctl.acc_load) begin
            acc_reg <= pp_reg;
        end else if (ctl.acc_add) begin
            acc_reg <= acc_reg + {pp_reg[HW-1:0], {HW{1'b0}}};
        end
        if (ctl.div_init) begin
            dvd_reg <= acc_reg ^ (acc_reg >> sm64br_pkg::MIX_SHIFT_C);
            rem_reg <= '0;
        end else if (ctl.div_step) begin
            dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
            rem_reg <= fits ? BW'(trial - {1'b0, bound_reg}) : trial[BW-1:0];
        end
        if (ctl.out_load) begin
            err_reg   <= (bound_reg == '0);
            value_reg <= (bound_reg == '0) ? '0 : rem_reg;
        end
    end

    assign m_value       = value_reg;
    assign m_bound_error = err_reg;

endmodule

[src/splitmix64_bounded_random_top.sv]
// Top level of the splitmix64 bounded random generator.
//
// Input channel s_valid / s_ready / s_bound carries one request per item: an
// exclusive upper bound. Result channel m_valid / m_ready / m_value /
// m_bound_error returns one item per request, in order.
// Each request advances the 64-bit state by the golden-ratio increment, mixes
// a copy with two xor-shift-multiply rounds and a closing xor-shift, then
// reduces it modulo the bound. A zero bound gives value 0 with bound_error set;
// the state still advances.
// Each 64-bit multiply runs as three 32x32 partial products in turn, and
// the modulo is a restoring divider producing one bit a cycle. One request
// is in flight at a time; s_ready rises again the cycle the result is
// loaded, so a new item is not taken before the last one is through.
// The result sits in an output register: a stalled receiver does not stop the
// next request from being accepted and computed, but the finished value waits
// until the register is free. Reset (aresetn low, synchronous) loads the state
// with 0x9E3779B97F4A7C15 and empties the pipeline.
module splitmix64_bounded_random_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sm64br_pkg::BOUND_W-1:0] s_bound,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sm64br_pkg::BOUND_W-1:0] m_value,
    output logic                           m_bound_error
);

    sm64br_pkg::ctl_t ctl;

    sm64br_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    sm64br_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .s_bound       (s_bound),
        .m_value       (m_value),
        .m_bound_error (m_bound_error)
    );

`ifndef SYNTHESIS
    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bound_error) |-> (m_value == '0))
        else $error("bound error item carries a nonzero value");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten before delivery");
`endif

endmodule
